// ===== rtl/core/mpbm_pkg.sv =====
`default_nettype none

package mpbm_pkg;

  // request opcodes
  typedef enum logic [1:0] {
    OP_WR_GOTO = 2'd0,
    OP_WR_NODE = 2'd1,
    OP_TEXT    = 2'd2,
    OP_NOP     = 2'd3
  } op_e;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_GOTO   = 2'd1,
    S_WALK   = 2'd2,
    S_FINISH = 2'd3
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic accept;     // request taken this cycle
    logic goto_step;  // goto read data valid, becomes current node
    logic walk_step;  // fail/tag read data valid, collect one node
    logic emit;       // load the result register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    op_e  op;         // opcode of the offered request
    logic tbl_ready;  // table_ready register
    logic bypass;     // offered byte is outside the alphabet
    logic in_last;    // offered byte ends its text
    logic goto_root;  // goto read returned the root
    logic walk_end;   // fail chain ends after this node
    logic last_q;     // byte in flight ends its text
    logic out_free;   // result register can take a new result
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/core/mpbm_in_if.sv =====
`default_nettype none

interface mpbm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [9:0]  node_index;
  logic [6:0]  symbol;
  logic [9:0]  target_node;
  logic [9:0]  fail_node;
  logic [63:0] tag_mask;
  logic [7:0]  text_byte;
  logic        last;

  modport source (
    output valid, op, node_index, symbol, target_node, fail_node, tag_mask, text_byte, last,
    input  ready
  );

  modport sink (
    input  valid, op, node_index, symbol, target_node, fail_node, tag_mask, text_byte, last,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/core/mpbm_out_if.sv =====
`default_nettype none

interface mpbm_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] hit_tags;
  logic        not_ready;

  modport source (
    output valid, hit_tags, not_ready,
    input  ready
  );

  modport sink (
    input  valid, hit_tags, not_ready,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/core/mpbm_ctrl.sv =====
`default_nettype none

module mpbm_ctrl (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  input  mpbm_pkg::status_t     status_i,
  output logic                  in_ready_o,
  output mpbm_pkg::cmd_t        cmd_o
);

  mpbm_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mpbm_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      mpbm_pkg::S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i && status_i.op == mpbm_pkg::OP_TEXT) begin
          priority if (!status_i.tbl_ready) begin
            state_d = mpbm_pkg::S_FINISH;
          end else if (status_i.bypass) begin
            state_d = status_i.in_last ? mpbm_pkg::S_FINISH : mpbm_pkg::S_IDLE;
          end else begin
            state_d = mpbm_pkg::S_GOTO;
          end
        end
      end
      mpbm_pkg::S_GOTO: begin
        cmd_o.goto_step = 1'b1;
        if (status_i.goto_root) begin
          state_d = status_i.last_q ? mpbm_pkg::S_FINISH : mpbm_pkg::S_IDLE;
        end else begin
          state_d = mpbm_pkg::S_WALK;
        end
      end
      mpbm_pkg::S_WALK: begin
        cmd_o.walk_step = 1'b1;
        if (status_i.walk_end) begin
          state_d = status_i.last_q ? mpbm_pkg::S_FINISH : mpbm_pkg::S_IDLE;
        end
      end
      mpbm_pkg::S_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = mpbm_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = mpbm_pkg::S_IDLE;
      end
    endcase
  end

  // a normal text byte always goes to the goto lookup
  a_text_to_goto: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.accept && status_i.op == mpbm_pkg::OP_TEXT && status_i.tbl_ready
     && !status_i.bypass) |=> state_q == mpbm_pkg::S_GOTO)
    else $error("text byte did not start a goto lookup");

  // the walk is only entered from the goto lookup or itself
  a_walk_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mpbm_pkg::S_WALK |->
      ($past(state_q) == mpbm_pkg::S_GOTO || $past(state_q) == mpbm_pkg::S_WALK))
    else $error("fail walk entered from wrong state");

  // a result can only be emitted for a byte that ends a text
  a_emit_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> status_i.last_q)
    else $error("result emitted mid text");

endmodule

`default_nettype wire

// ===== rtl/core/mpbm_dp.sv =====
`default_nettype none

module mpbm_dp #(
  parameter int NODES    = 1024,
  parameter int ALPHABET = 128,
  parameter int TAGS     = 64
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   cfg_we_i,
  input  wire                   cfg_data_i,
  input  wire  [1:0]            op_i,
  input  wire  [9:0]            node_index_i,
  input  wire  [6:0]            symbol_i,
  input  wire  [9:0]            target_node_i,
  input  wire  [9:0]            fail_node_i,
  input  wire  [63:0]           tag_mask_i,
  input  wire  [7:0]            text_byte_i,
  input  wire                   last_i,
  input  mpbm_pkg::cmd_t        cmd_i,
  output mpbm_pkg::status_t     status_o,
  mpbm_out_if.source            out_rsp
);

  localparam int NW = $clog2(NODES);
  localparam int SW = $clog2(ALPHABET);
  localparam int CW = $clog2(NODES + 1);
  localparam int GOTO_DEPTH = NODES * (2 ** SW);

  // storage
  logic [NW-1:0]   goto_mem [GOTO_DEPTH];
  logic [NW-1:0]   fail_mem [NODES];
  logic [TAGS-1:0] tag_mem  [NODES];

  logic [NW-1:0]   goto_rd_q;
  logic [NW-1:0]   fail_rd_q;
  logic [TAGS-1:0] tag_rd_q;

  logic            tbl_ready_q;
  logic [NW-1:0]   cur_q;
  logic [TAGS-1:0] hit_q;
  logic            last_q;
  logic            err_q;
  logic [CW-1:0]   steps_q;
  logic            out_valid_q;
  logic [TAGS-1:0] out_hits_q;
  logic            out_nr_q;

  // request decode
  logic [31:0]     node32, sym32, tgt32, fail32, byte32;
  logic [NW-1:0]   node_idx, tgt_node, fail_lnk;
  logic [SW-1:0]   wr_sym, text_sym;
  logic            node_ok, sym_ok, bypass, op_text, text_err;
  logic [NW-1:0]   walk_addr;
  logic [CW-1:0]   steps_inc;
  mpbm_pkg::op_e   op;

  assign op       = mpbm_pkg::op_e'(op_i);
  assign node32   = 32'(node_index_i);
  assign sym32    = 32'(symbol_i);
  assign tgt32    = 32'(target_node_i);
  assign fail32   = 32'(fail_node_i);
  assign byte32   = 32'(text_byte_i);
  assign node_idx = node32[NW-1:0];
  assign wr_sym   = sym32[SW-1:0];
  assign text_sym = byte32[SW-1:0];
  assign node_ok  = node32 < 32'(NODES);
  assign sym_ok   = sym32 < 32'(ALPHABET);
  assign bypass   = byte32 >= 32'(ALPHABET);
  // out of range links fall back to the root
  assign tgt_node = (tgt32 < 32'(NODES)) ? tgt32[NW-1:0] : '0;
  assign fail_lnk = (fail32 < 32'(NODES)) ? fail32[NW-1:0] : '0;

  assign op_text  = cmd_i.accept && op == mpbm_pkg::OP_TEXT;
  assign text_err = !tbl_ready_q;

  assign walk_addr = cmd_i.goto_step ? goto_rd_q : fail_rd_q;
  assign steps_inc = steps_q + CW'(1);

  // goto table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && op == mpbm_pkg::OP_WR_GOTO && node_ok && sym_ok) begin
      goto_mem[{node_idx, wr_sym}] <= tgt_node;
    end
    if (op_text) begin
      goto_rd_q <= goto_mem[{cur_q, text_sym}];
    end
  end

  // per-node fail link and tag mask
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && op == mpbm_pkg::OP_WR_NODE && node_ok) begin
      fail_mem[node_idx] <= fail_lnk;
      tag_mem[node_idx]  <= tag_mask_i[TAGS-1:0];
    end
    if (cmd_i.goto_step || cmd_i.walk_step) begin
      fail_rd_q <= fail_mem[walk_addr];
      tag_rd_q  <= tag_mem[walk_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tbl_ready_q <= 1'b0;
      cur_q       <= '0;
      hit_q       <= '0;
      last_q      <= 1'b0;
      err_q       <= 1'b0;
      steps_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        tbl_ready_q <= cfg_data_i;
      end
      if (op_text) begin
        last_q <= last_i || text_err;
        err_q  <= text_err;
        if (text_err) begin
          hit_q <= '0;
          cur_q <= '0;
        end else if (bypass) begin
          cur_q <= '0;
        end
      end
      if (cmd_i.goto_step) begin
        cur_q   <= goto_rd_q;
        steps_q <= '0;
      end
      if (cmd_i.walk_step) begin
        hit_q   <= hit_q | tag_rd_q;
        steps_q <= steps_inc;
      end
      if (cmd_i.emit) begin
        hit_q       <= '0;
        cur_q       <= '0;
        out_valid_q <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_hits_q <= hit_q;
      out_nr_q   <= err_q;
    end
  end

  assign out_rsp.valid     = out_valid_q;
  assign out_rsp.hit_tags  = 64'(out_hits_q);
  assign out_rsp.not_ready = out_nr_q;

  assign status_o.op        = op;
  assign status_o.tbl_ready = tbl_ready_q;
  assign status_o.bypass    = bypass;
  assign status_o.in_last   = last_i;
  assign status_o.goto_root = goto_rd_q == '0;
  assign status_o.walk_end  = (fail_rd_q == '0) || (steps_inc == CW'(NODES));
  assign status_o.last_q    = last_q;
  assign status_o.out_free  = !out_valid_q || out_rsp.ready;

  // current node never leaves the table
  a_cur_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cur_q) < 32'(NODES))
    else $error("current node out of range");

  // the step cap bounds the fail walk
  a_step_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.walk_step |-> 32'(steps_q) < 32'(NODES))
    else $error("fail walk exceeded node count");

  // a waiting result stays put until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_rsp.valid && !out_rsp.ready) |=>
      (out_rsp.valid && $stable(out_rsp.hit_tags) && $stable(out_rsp.not_ready)))
    else $error("waiting result changed before it was taken");

endmodule

`default_nettype wire

// ===== rtl/core/multi_pattern_byte_matcher.sv =====
`default_nettype none

// multi-pattern byte matcher: scans text bytes against a host-loaded match
// automaton (goto table, fail links, per-node tag masks) and reports, once per
// text, the set of tags matched anywhere in it. requests with op 0 and 1 load
// the tables; set table_ready through cfg_we_i/cfg_data_i once loading is done.
// a text byte is accepted as the goto table is read; then the new node is
// taken and, unless it is the root, it and the non-root nodes on its fail chain
// are walked one at a time (at most NODES of them), since each fail-link read
// depends on the one before. a byte of ALPHABET or more, and a byte sent while
// table_ready is low, skips the goto step and the walk. the byte that ends a
// text then loads the result register once an earlier result waiting there is
// taken; that register lets the next request in while a result still waits. a
// text byte sent while table_ready is low yields one result with not_ready set
// and hit_tags zero, and drops the text. bytes of ALPHABET or more return the
// scan to the root. the tables come up unwritten after reset, with no clearing
// pass: load every entry a scan can reach.
module multi_pattern_byte_matcher #(
  parameter int NODES    = 1024,
  parameter int ALPHABET = 128,
  parameter int TAGS     = 64
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          cfg_we_i,
  input  wire          cfg_data_i,
  mpbm_in_if.sink      in_req,
  mpbm_out_if.source   out_rsp
);

  mpbm_pkg::cmd_t    cmd;
  mpbm_pkg::status_t status;
  logic              in_ready;

  // sequencer: one request at a time, walks the fail chain
  mpbm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_req.valid),
    .status_i   (status),
    .in_ready_o (in_ready),
    .cmd_o      (cmd)
  );

  assign in_req.ready = in_ready;

  // tables, scan state, hit set and result register
  mpbm_dp #(
    .NODES    (NODES),
    .ALPHABET (ALPHABET),
    .TAGS     (TAGS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .op_i          (in_req.op),
    .node_index_i  (in_req.node_index),
    .symbol_i      (in_req.symbol),
    .target_node_i (in_req.target_node),
    .fail_node_i   (in_req.fail_node),
    .tag_mask_i    (in_req.tag_mask),
    .text_byte_i   (in_req.text_byte),
    .last_i        (in_req.last),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_rsp       (out_rsp)
  );

endmodule

`default_nettype wire
